// ===== sv/nsl_pkg.sv =====
// Package for the nearest sample lookup: constants, codes and controller/datapath types.
`timescale 1ns / 1ps
`default_nettype none
package nsl_pkg;

  localparam int BucketsDef = 16;
  localparam int MapRows    = 18;
  localparam int PedalRows  = 16;

  localparam logic [4:0] ChicRow   = 5'd16;
  localparam logic [4:0] SplashRow = 5'd17;

  localparam logic [1:0] FuncClear  = 2'd0;
  localparam logic [1:0] FuncSet    = 2'd1;
  localparam logic [1:0] FuncLookup = 2'd2;

  localparam logic [1:0] KindNormal = 2'd0;
  localparam logic [1:0] KindChic   = 2'd1;
  localparam logic [1:0] KindSplash = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // take the input item, apply clear/set
    logic row_probe;  // probe pedal rows at the current distance
    logic load_row;   // fetch the chosen row into the bit search register
    logic bit_probe;  // probe volume buckets at the current distance
    logic emit;       // copy working result into the output register
  } nsl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_lookup;   // item at the input is a lookup
    logic in_special;  // item at the input is a chic or splash lookup
    logic row_hit;
    logic row_last;
    logic bit_hit;
    logic bit_last;
  } nsl_sts_t;

endpackage
`default_nettype wire

// ===== sv/nearest_sample_lookup.sv =====
// Top level of the nearest sample lookup: controller plus datapath.
// Clear and set items: accepted, result ready after the capture and finish steps.
// Normal lookup: capture, up to 16 row probes, row load, up to Buckets bucket
// probes, finish; one item at a time, set by the serial row probe and bucket
// probe loops. A new item is taken while a result waits.
// Reset (rst_n low, synchronous) empties the map and drops any pending result.
`timescale 1ns / 1ps
`default_nettype none
module nearest_sample_lookup
  import nsl_pkg::*;
#(
  parameter int Buckets = BucketsDef
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input items
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_func,
  input  wire logic [4:0] in_row_index,
  input  wire logic [3:0] in_bit_index,
  input  wire logic [3:0] in_pedal_position,
  input  wire logic [7:0] in_volume_level,
  input  wire logic [1:0] in_sound_kind,
  // result items
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_found,
  output logic [3:0]      out_chosen_position,
  output logic [3:0]      out_chosen_volume
);

  nsl_cmd_t cmd;
  nsl_sts_t sts;

  // Sequencer: walks capture, row search, row fetch, bucket search, finish.
  nsl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Map storage, probe units and the output register.
  nsl_dp #(
    .Buckets (Buckets)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_func             (in_func),
    .in_row_index        (in_row_index),
    .in_bit_index        (in_bit_index),
    .in_pedal_position   (in_pedal_position),
    .in_volume_level     (in_volume_level),
    .in_sound_kind       (in_sound_kind),
    .out_found           (out_found),
    .out_chosen_position (out_chosen_position),
    .out_chosen_volume   (out_chosen_volume)
  );

endmodule
`default_nettype wire

// ===== sv/nsl_ctrl.sv =====
// Controller state machine of the nearest sample lookup.
`timescale 1ns / 1ps
`default_nettype none
module nsl_ctrl
  import nsl_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire nsl_sts_t sts,
  output nsl_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ROW  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_BIT  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       can_emit;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign can_emit  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (!sts.in_lookup) begin
            state_nxt = S_FIN;
          end else if (sts.in_special) begin
            state_nxt = S_LOAD;
          end else begin
            state_nxt = S_ROW;
          end
        end
      end
      S_ROW: begin
        cmd.row_probe = 1'b1;
        if (sts.row_hit) begin
          state_nxt = S_LOAD;
        end else if (sts.row_last) begin
          state_nxt = S_FIN;
        end
      end
      S_LOAD: begin
        cmd.load_row = 1'b1;
        state_nxt    = S_BIT;
      end
      S_BIT: begin
        cmd.bit_probe = 1'b1;
        if (sts.bit_hit || sts.bit_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (can_emit) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/nsl_dp.sv =====
// Datapath of the nearest sample lookup: availability map, probe counters, result registers.
`timescale 1ns / 1ps
`default_nettype none
module nsl_dp
  import nsl_pkg::*;
#(
  parameter int Buckets = BucketsDef
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire nsl_cmd_t   cmd,
  output nsl_sts_t        sts,
  input  wire logic [1:0] in_func,
  input  wire logic [4:0] in_row_index,
  input  wire logic [3:0] in_bit_index,
  input  wire logic [3:0] in_pedal_position,
  input  wire logic [7:0] in_volume_level,
  input  wire logic [1:0] in_sound_kind,
  output logic            out_found,
  output logic [3:0]      out_chosen_position,
  output logic [3:0]      out_chosen_volume
);

  localparam int BW = $clog2(Buckets);

  logic [Buckets-1:0] map_r [MapRows];
  logic [MapRows-1:0] ne_r;          // row holds at least one set bit
  logic [PedalRows-1:0] ne_ped;

  logic [3:0]         pedal_r;
  logic [BW-1:0]      want_r;
  logic               special_r;
  logic [4:0]         row_sel_r;
  logic [3:0]         d_r;
  logic [BW-1:0]      e_r;
  logic [Buckets-1:0] bits_r;

  logic               found_w_r;
  logic [3:0]         pos_w_r;
  logic [3:0]         vol_w_r;

  logic [BW-1:0]      want_in;
  logic [12:0]        want_prod;
  logic               in_special;

  logic [4:0]         up_row;
  logic [3:0]         dn_row;
  logic               up_row_ok, dn_row_ok;
  logic [BW:0]        up_bit;
  logic [BW-1:0]      dn_bit;
  logic               up_bit_ok, dn_bit_ok;
  logic               set_ok;

  assign want_prod  = 13'(in_volume_level) * 13'(Buckets);
  assign want_in    = want_prod[8 +: BW];
  assign in_special = (in_sound_kind == KindChic) || (in_sound_kind == KindSplash);
  assign set_ok     = (in_row_index < 5'(MapRows)) && (5'(in_bit_index) < 5'(Buckets));

  // Row probe: above first, then below, bounded at row zero.
  assign ne_ped    = ne_r[PedalRows-1:0];
  assign up_row    = {1'b0, pedal_r} + {1'b0, d_r};
  assign dn_row    = pedal_r - d_r;
  assign up_row_ok = !up_row[4] && ne_ped[up_row[3:0]];
  assign dn_row_ok = (d_r <= pedal_r) && ne_ped[dn_row];

  // Bucket probe: upward first, then downward.
  assign up_bit    = {1'b0, want_r} + {1'b0, e_r};
  assign dn_bit    = want_r - e_r;
  assign up_bit_ok = (up_bit < (BW+1)'(Buckets)) && bits_r[up_bit[BW-1:0]];
  assign dn_bit_ok = (e_r <= want_r) && bits_r[dn_bit];

  always_comb begin
    sts.in_lookup  = (in_func == FuncLookup);
    sts.in_special = in_special;
    sts.row_hit    = up_row_ok || dn_row_ok;
    sts.row_last   = (d_r == 4'(PedalRows - 1));
    sts.bit_hit    = up_bit_ok || dn_bit_ok;
    sts.bit_last   = (e_r == BW'(Buckets - 1));
  end

  // Map and emptiness flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < MapRows; r++) begin
        map_r[r] <= '0;
      end
      ne_r <= '0;
    end else if (cmd.capture) begin
      if (in_func == FuncClear) begin
        for (int r = 0; r < MapRows; r++) begin
          map_r[r] <= '0;
        end
        ne_r <= '0;
      end else if (in_func == FuncSet && set_ok) begin
        map_r[in_row_index][in_bit_index[BW-1:0]] <= 1'b1;
        ne_r[in_row_index]                        <= 1'b1;
      end
    end
  end

  // Item registers, counters and working result.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pedal_r   <= in_pedal_position;
      want_r    <= want_in;
      special_r <= in_special;
      row_sel_r <= (in_sound_kind == KindChic) ? ChicRow : SplashRow;
      d_r       <= '0;
      found_w_r <= 1'b0;
      pos_w_r   <= '0;
      vol_w_r   <= '0;
    end
    if (cmd.row_probe) begin
      if (up_row_ok) begin
        row_sel_r <= up_row;
      end else if (dn_row_ok) begin
        row_sel_r <= {1'b0, dn_row};
      end else if (sts.row_last) begin
        found_w_r <= 1'b0;
        pos_w_r   <= pedal_r;
        vol_w_r   <= 4'(want_r);
      end else begin
        d_r <= d_r + 4'd1;
      end
    end
    if (cmd.load_row) begin
      bits_r  <= map_r[row_sel_r];
      e_r     <= '0;
      pos_w_r <= special_r ? 4'd0 : row_sel_r[3:0];
    end
    if (cmd.bit_probe) begin
      if (up_bit_ok) begin
        found_w_r <= 1'b1;
        vol_w_r   <= 4'(up_bit[BW-1:0]);
      end else if (dn_bit_ok) begin
        found_w_r <= 1'b1;
        vol_w_r   <= 4'(dn_bit);
      end else if (sts.bit_last) begin
        found_w_r <= 1'b0;
        vol_w_r   <= 4'(want_r);
      end else begin
        e_r <= e_r + BW'(1);
      end
    end
    if (cmd.emit) begin
      out_found           <= found_w_r;
      out_chosen_position <= pos_w_r;
      out_chosen_volume   <= vol_w_r;
    end
  end

endmodule
`default_nettype wire
